/* hw/rtl/sha_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sha_pkg: shared types, constants and functions for the SHA-256 engine
// Round constants, initial hash values, sigma functions and the control
// structs that run between the sequencer and its datapath blocks.
// ----------------------------------------------------------------------------
package sha_pkg;

	localparam int BlockBytes = 64;
	localparam int LenOffset  = 56;
	localparam logic [7:0] PadMark = 8'h80;
	localparam logic [63:0] BlockBits = 64'd512;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef enum logic [1:0] {
		PAD_WITH_LEN,
		PAD_NO_LEN,
		PAD_LEN_ONLY
	} pad_mode_t;

	typedef struct packed {
		logic        shift;
		logic        byte_we;
		logic [5:0]  byte_sel;
		logic [7:0]  byte_val;
		logic        pad_load;
		pad_mode_t   pad_mode;
		logic [5:0]  pad_cnt;
		logic [63:0] total;
	} sched_ctl_t;

	typedef struct packed {
		logic        init;
		logic        step;
		logic        fold;
		logic        restart;
		logic [31:0] k;
	} round_ctl_t;

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'd0, x[31:3]};
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/sha_sched.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sha_sched: block buffer and message schedule
// Sixteen 32-bit words collect incoming bytes big-endian, take the padding
// and length, and during compression shift out W[t] while expanding W[t+16].
// ----------------------------------------------------------------------------
module sha_sched (
	input  wire                 clk,
	input  sha_pkg::sched_ctl_t ctl,
	output logic [31:0]         w_cur
);

	logic [15:0][31:0] w_q;
	logic [15:0][31:0] w_d;
	logic [31:0]       w_new;

	assign w_new = sha_pkg::ssig1(w_q[14]) + w_q[9] + sha_pkg::ssig0(w_q[1]) + w_q[0];
	assign w_cur = w_q[0];

	always_comb begin
		w_d = w_q;
		if (ctl.shift) begin
			for (int i = 0; i < 15; i++) begin
				w_d[i] = w_q[i + 1];
			end
			w_d[15] = w_new;
		end else if (ctl.pad_load) begin
			for (int j = 0; j < 16; j++) begin
				for (int k = 0; k < 4; k++) begin
					if (ctl.pad_mode == sha_pkg::PAD_LEN_ONLY || 6'(4 * j + k) > ctl.pad_cnt) begin
						w_d[j][31 - 8 * k -: 8] = 8'd0;
					end else if (6'(4 * j + k) == ctl.pad_cnt) begin
						w_d[j][31 - 8 * k -: 8] = sha_pkg::PadMark;
					end
				end
			end
			if (ctl.pad_mode != sha_pkg::PAD_NO_LEN) begin
				w_d[14] = ctl.total[63:32];
				w_d[15] = ctl.total[31:0];
			end
		end else if (ctl.byte_we) begin
			for (int k = 0; k < 4; k++) begin
				if (2'(k) == ctl.byte_sel[1:0]) begin
					w_d[ctl.byte_sel[5:2]][31 - 8 * k -: 8] = ctl.byte_val;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		w_q <= w_d;
	end

endmodule
`default_nettype wire

/* hw/rtl/sha_round.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sha_round: compression round unit and hash words
// One round per step on the a..h working registers; fold adds them back
// into the hash words at the end of a block.
// ----------------------------------------------------------------------------
module sha_round (
	input  wire                 clk,
	input  wire                 arst_n,
	input  sha_pkg::round_ctl_t ctl,
	input  wire  [31:0]         w_cur,
	output logic [7:0][31:0]    hash
);

	logic [7:0][31:0] hash_q;
	logic [7:0][31:0] v_q;
	logic [31:0]      t1;
	logic [31:0]      t2;
	logic [31:0]      ch;
	logic [31:0]      maj;

	assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1  = v_q[7] + sha_pkg::bsig1(v_q[4]) + ch + ctl.k + w_cur;
	assign t2  = sha_pkg::bsig0(v_q[0]) + maj;
	assign hash = hash_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= sha_pkg::INIT_HASH[i];
			end
		end else if (ctl.restart) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= sha_pkg::INIT_HASH[i];
			end
		end else if (ctl.fold) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= hash_q[i] + v_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			v_q <= hash_q;
		end else if (ctl.step) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/sha256_hash_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_hash_engine: SHA-256 over a byte stream
// Sequencer that fills the block buffer, pads, runs 64 rounds per block on
// the shared round unit and streams out the eight digest words.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                | tuser        | tlast
//  s_*     | in  | [7:0] msg_byte       | byte_present | end_of_message
//  m_*     | out | [31:0] digest_word,  | -            | last_word
//          |     | [34:32] word_index   |              |
//
// A beat that neither completes a block nor ends the message is taken while
// the engine stays idle. The 64th byte of a block starts the 64 rounds and the
// fold into the hash words before s_tready returns. End of message: padding
// and compression, with a second block when the length needs its own, then
// eight output beats, one per cycle when m_tready is held. Reset restores the
// initial hash and an empty message. s_tready is low while a block
// compresses and, after an end of message, until the last digest beat.
module sha256_hash_engine (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] msg_byte
	input  wire  [0:0]  s_tuser,   // [0] byte_present
	input  wire         s_tlast,
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index
	output logic        m_tlast
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		BLK_DATA,
		BLK_PAD1,
		BLK_LAST
	} blk_kind_t;

	state_t              state_q;
	blk_kind_t           kind_q;
	logic [5:0]          rnd_q;
	logic [5:0]          pend_q;
	logic [63:0]         bitlen_q;
	logic                eom_q;
	logic [2:0]          oidx_q;
	logic                s_acc;
	logic                m_acc;
	sha_pkg::sched_ctl_t sc;
	sha_pkg::round_ctl_t rc;
	logic [31:0]         w_cur;
	logic [7:0][31:0]    hash;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = (state_q == ST_OUT);
	assign m_acc    = m_tvalid && m_tready;
	assign m_tdata  = {5'd0, oidx_q, hash[oidx_q]};
	assign m_tlast  = (oidx_q == 3'd7);

	always_comb begin
		sc.shift    = (state_q == ST_ROUND);
		sc.byte_we  = s_acc && s_tuser[0];
		sc.byte_sel = pend_q;
		sc.byte_val = s_tdata;
		sc.pad_load = (state_q == ST_PAD);
		sc.pad_cnt  = pend_q;
		sc.total    = bitlen_q + {55'd0, pend_q, 3'd0};
		if (kind_q == BLK_PAD1) begin
			sc.pad_mode = sha_pkg::PAD_LEN_ONLY;
		end else if (pend_q >= 6'(sha_pkg::LenOffset)) begin
			sc.pad_mode = sha_pkg::PAD_NO_LEN;
		end else begin
			sc.pad_mode = sha_pkg::PAD_WITH_LEN;
		end
		rc.init    = (sc.byte_we && pend_q == 6'(sha_pkg::BlockBytes - 1)) || (state_q == ST_PAD);
		rc.step    = (state_q == ST_ROUND);
		rc.fold    = (state_q == ST_FOLD);
		rc.restart = m_acc && m_tlast;
		rc.k       = sha_pkg::ROUND_K[rnd_q];
	end

	sha_sched u_sched (
		.clk   (clk),
		.ctl   (sc),
		.w_cur (w_cur)
	);

	sha_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rc),
		.w_cur  (w_cur),
		.hash   (hash)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			kind_q   <= BLK_DATA;
			rnd_q    <= '0;
			pend_q   <= '0;
			bitlen_q <= '0;
			eom_q    <= 1'b0;
			oidx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						kind_q <= BLK_DATA;
						eom_q  <= s_tlast;
						if (s_tuser[0]) begin
							pend_q <= pend_q + 6'd1;
						end
						if (s_tuser[0] && pend_q == 6'(sha_pkg::BlockBytes - 1)) begin
							rnd_q   <= '0;
							state_q <= ST_ROUND;
						end else if (s_tlast) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					unique case (kind_q)
						BLK_DATA: begin
							bitlen_q <= bitlen_q + sha_pkg::BlockBits;
							state_q  <= eom_q ? ST_PAD : ST_IDLE;
						end
						BLK_PAD1: state_q <= ST_PAD;
						BLK_LAST: begin
							oidx_q  <= '0;
							state_q <= ST_OUT;
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_PAD: begin
					// pad the tail; on a long tail the length goes into a second block
					rnd_q   <= '0;
					kind_q  <= (sc.pad_mode == sha_pkg::PAD_NO_LEN) ? BLK_PAD1 : BLK_LAST;
					state_q <= ST_ROUND;
				end
				ST_OUT: begin
					if (m_acc) begin
						if (m_tlast) begin
							pend_q   <= '0;
							bitlen_q <= '0;
							kind_q   <= BLK_DATA;
							eom_q    <= 1'b0;
							state_q  <= ST_IDLE;
						end else begin
							oidx_q <= oidx_q + 3'd1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("digest beat offered while input is open");

	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && rnd_q == 6'd63) |=> (state_q == ST_FOLD))
		else $error("round 63 not followed by fold");

	a_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && s_tuser[0] && pend_q == 6'd63) |=> (state_q == ST_ROUND && pend_q == 6'd0))
		else $error("full block did not start compression");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(m_acc && m_tlast) |=> (s_tready && pend_q == 6'd0 && bitlen_q == 64'd0))
		else $error("engine not reset after digest");

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sha256_hash_engine
// Streams byte messages into the engine and compares every digest word with
// a SHA-256 computed alongside in the bench. Short directed messages come
// first, then random messages with lengths clustered at the padding and
// block boundaries. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CLK_HALF      = 2;
	localparam int RESET_CYCLES  = 8;
	localparam int IDLE_PCT      = 7;
	localparam int RANDOM_BEATS  = 340;
	localparam int STEADY_FIRST  = 120;
	localparam int STEADY_LAST   = 220;
	localparam int NOISE_PCT     = 10;
	localparam int TAIL_CYCLES   = 160;
	localparam int STALL_LIMIT   = 3000;
	localparam int BLOCK_SIZE    = 64;
	localparam int LENGTH_SLOT   = 56;
	localparam bit [7:0] PAD_BYTE = 8'h80;

	localparam int BOUNDARY_LENS [12] = '{54, 55, 56, 57, 62, 63, 64, 65, 119, 120, 127, 128};

	localparam bit [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam bit [31:0] SHA_H0 [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct {
		bit [31:0] word;
		bit [2:0]  idx;
		bit        last;
	} digest_beat_t;

	// running SHA-256 state plus the digest words still owed by the engine
	class digest_tracker;
		bit [31:0]    hash [8];
		bit [7:0]     blk [64];
		int           fill;
		bit [63:0]    bits_done;
		digest_beat_t digest_due [$];
		int           errors;
		int           words_checked;
		int           messages;
		int           bytes_taken;

		function new();
			restart();
			errors = 0;
			words_checked = 0;
			messages = 0;
			bytes_taken = 0;
		endfunction

		function void restart();
			for (int j = 0; j < 8; j++)
				hash[j] = SHA_H0[j];
			fill = 0;
			bits_done = '0;
		endfunction

		static function bit [31:0] rotr(bit [31:0] x, int n);
			return (x >> n) | (x << (32 - n));
		endfunction

		function void compress();
			bit [31:0] w [64];
			bit [31:0] v [8];
			bit [31:0] t1, t2, ch, maj;
			for (int j = 0; j < 16; j++)
				w[j] = {blk[4*j], blk[4*j+1], blk[4*j+2], blk[4*j+3]};
			for (int j = 16; j < 64; j++)
				w[j] = (rotr(w[j-2], 17) ^ rotr(w[j-2], 19) ^ (w[j-2] >> 10)) + w[j-7]
					+ (rotr(w[j-15], 7) ^ rotr(w[j-15], 18) ^ (w[j-15] >> 3)) + w[j-16];
			for (int j = 0; j < 8; j++)
				v[j] = hash[j];
			for (int j = 0; j < 64; j++) begin
				ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
				maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
				t1  = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) + ch
					+ SHA_K[j] + w[j];
				t2  = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) + maj;
				v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
				v[4] = v[3] + t1;
				v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
				v[0] = t1 + t2;
			end
			for (int j = 0; j < 8; j++)
				hash[j] += v[j];
		endfunction

		// one accepted input beat
		function void note_beat(bit [7:0] data, bit present, bit ending);
			bit [63:0]    total;
			int           pos;
			digest_beat_t beat;
			if (present) begin
				blk[fill] = data;
				fill++;
				bytes_taken++;
				if (fill == BLOCK_SIZE) begin
					compress();
					bits_done += 64'd512;
					fill = 0;
				end
			end
			if (!ending)
				return;
			total = bits_done + 64'(fill) * 64'd8;
			blk[fill] = PAD_BYTE;
			pos = fill + 1;
			// no room for the length: pad out and spend an extra block
			if (fill >= LENGTH_SLOT) begin
				while (pos < BLOCK_SIZE) begin
					blk[pos] = 8'h00;
					pos++;
				end
				compress();
				pos = 0;
			end
			while (pos < LENGTH_SLOT) begin
				blk[pos] = 8'h00;
				pos++;
			end
			for (int j = 0; j < 8; j++)
				blk[LENGTH_SLOT + j] = total[63 - 8*j -: 8];
			compress();
			for (int j = 0; j < 8; j++) begin
				beat.word = hash[j];
				beat.idx  = 3'(j);
				beat.last = (j == 7);
				digest_due.push_back(beat);
			end
			messages++;
			restart();
		endfunction

		// one accepted output beat
		function void check_word(bit [31:0] word, bit [2:0] idx, bit last);
			digest_beat_t want;
			if (digest_due.size() == 0) begin
				$display("%0t: unexpected digest beat word=%h idx=%0d last=%0b",
					$time, word, idx, last);
				errors++;
				return;
			end
			want = digest_due.pop_front();
			words_checked++;
			if (word !== want.word || idx !== want.idx || last !== want.last) begin
				$display("%0t: digest mismatch expected word=%h idx=%0d last=%0b, got word=%h idx=%0d last=%0b",
					$time, want.word, want.idx, want.last, word, idx, last);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic [0:0]  s_tuser = 1'b0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;

	bit            steady = 1'b0;
	int            random_beats = 0;
	int            stall_count = 0;
	digest_tracker sb;

	sha256_hash_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_beat(s_tdata, s_tuser[0], s_tlast);
			if (m_tvalid && m_tready)
				sb.check_word(m_tdata[31:0], m_tdata[34:32], m_tlast);
		end
	end

	// stall watchdog: no beat on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_count <= 0;
		end else if (stall_count >= STALL_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end else begin
			stall_count <= stall_count + 1;
		end
	end

	task automatic send_beat(input bit [7:0] data, input bit present, input bit ending);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= present;
		s_tlast  <= ending;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	function automatic bit [7:0] pick_byte();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic int pick_length();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return $urandom_range(0, 20);
		if (roll < 80)
			return BOUNDARY_LENS[$urandom_range(0, 11)];
		return $urandom_range(0, 140);
	endfunction

	// a message with random content; idle beats sprinkled in as noise
	task automatic send_message(input int len, input bit byte_on_end);
		for (int j = 0; j < len; j++) begin
			if ($urandom_range(0, 99) < NOISE_PCT) begin
				send_beat(8'($urandom), 1'b0, 1'b0);
				random_beats++;
			end
			send_beat(pick_byte(), 1'b1, byte_on_end && j == len - 1);
			random_beats++;
			steady = random_beats >= STEADY_FIRST && random_beats < STEADY_LAST;
		end
		if (!byte_on_end || len == 0) begin
			send_beat(8'($urandom), 1'b0, 1'b1);
			random_beats++;
		end
	endtask

	initial begin
		sb = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle beat, then empty message
		send_beat(8'h5a, 1'b0, 1'b0);
		send_beat(8'ha5, 1'b0, 1'b1);
		// single-byte messages at the byte extremes and the pad value, byte and end on one beat
		send_beat(8'h00, 1'b1, 1'b1);
		send_beat(8'hff, 1'b1, 1'b1);
		send_beat(8'h80, 1'b1, 1'b1);
		// "abc"
		send_beat(8'h61, 1'b1, 1'b0);
		send_beat(8'h62, 1'b1, 1'b0);
		send_beat(8'h63, 1'b1, 1'b1);
		// bytes, an ignored beat, then end without a byte
		send_beat(8'h61, 1'b1, 1'b0);
		send_beat(8'hc3, 1'b0, 1'b0);
		send_beat(8'hff, 1'b1, 1'b0);
		send_beat(8'h3c, 1'b0, 1'b1);

		while (random_beats < RANDOM_BEATS)
			send_message(pick_length(), $urandom_range(0, 1));
		s_tvalid <= 1'b0;
		steady = 1'b0;

		while (sb.digest_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Hashed %0d messages, %0d message bytes, lengths up to two blocks plus padding",
			sb.messages, sb.bytes_taken);
		$display("Compared %0d digest words, %0d errors", sb.words_checked, sb.errors);
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/sha_pkg.sv
hw/rtl/sha_sched.sv
hw/rtl/sha_round.sv
hw/rtl/sha256_hash_engine.sv
tb/testbench.sv
